[rtl/core/lfr_pkg.sv]
// Package for the LIN frame receiver: command codes, parser states,
// header constants and the event struct passed from parser to top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lfr_pkg;

  localparam int unsigned DefaultBufferDepth = 64;

  localparam logic [7:0] SyncByte    = 8'h55;
  localparam logic [3:0] MinDataLen  = 4'd1;
  localparam logic [3:0] MaxDataLen  = 4'd8;
  localparam logic [5:0] AvailMax    = 6'd63;

  typedef enum logic [1:0] {
    CMD_BREAK = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } lfr_cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SYNC  = 5'b00010,
    ST_IDENT = 5'b00100,
    ST_DATA  = 5'b01000,
    ST_CHECK = 5'b10000
  } lfr_state_e;

  // parser decisions for one item
  typedef struct packed {
    logic push;   // data byte wants to go into the buffer
    logic flush;  // checksum mismatch
    logic good;   // checksum match
    logic rej;    // bad sync or identifier parity
  } lfr_evt_t;

  // stage between parser and output register
  typedef struct packed {
    logic       pop;
    logic [5:0] avail;
    logic       good;
    logic       failed;
    logic       rej;
    logic       ovf;
  } lfr_res_t;

endpackage

`default_nettype wire

[rtl/core/lfr_parser.sv]
// LIN frame parser: break/sync/identifier/data/checksum sequencing with
// identifier parity check and enhanced (carry-folded) checksum.
// Depends on lfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfr_parser
  import lfr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [1:0] cmd_i,
  input  wire logic [7:0] byte_i,
  input  wire logic [3:0] data_len_i,
  output lfr_evt_t        evt_o
);

  lfr_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;

  logic       p0, p1, par_ok;
  logic [8:0] sum9;
  logic [7:0] sum_fold;
  logic [3:0] len;
  logic [3:0] cnt_inc;

  assign p0     = byte_i[0] ^ byte_i[1] ^ byte_i[2] ^ byte_i[4];
  assign p1     = ~(byte_i[1] ^ byte_i[3] ^ byte_i[4] ^ byte_i[5]);
  assign par_ok = (byte_i[7] == p1) && (byte_i[6] == p0);

  // end-around carry; the +1 can never carry again
  assign sum9     = {1'b0, sum_q} + {1'b0, byte_i};
  assign sum_fold = sum9[8] ? (sum9[7:0] + 8'd1) : sum9[7:0];

  assign len = (data_len_i < MinDataLen) ? MinDataLen :
               (data_len_i > MaxDataLen) ? MaxDataLen : data_len_i;
  assign cnt_inc = cnt_q + 4'd1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    evt_o   = '0;
    if (accept_i) begin
      if (cmd_i == CMD_BREAK) begin
        state_d = ST_SYNC;
      end else if (cmd_i == CMD_BYTE) begin
        case (state_q)
          ST_IDLE: begin
            state_d = ST_IDLE;
          end
          ST_SYNC: begin
            if (byte_i == SyncByte) begin
              state_d = ST_IDENT;
            end else begin
              state_d   = ST_IDLE;
              evt_o.rej = 1'b1;
            end
          end
          ST_IDENT: begin
            if (par_ok) begin
              sum_d   = byte_i;
              cnt_d   = '0;
              state_d = ST_DATA;
            end else begin
              state_d   = ST_IDLE;
              evt_o.rej = 1'b1;
            end
          end
          ST_DATA: begin
            evt_o.push = 1'b1;
            if (cnt_inc < len) begin
              sum_d = sum_fold;
              cnt_d = cnt_inc;
            end else begin
              sum_d   = ~sum_fold;
              cnt_d   = '0;
              state_d = ST_CHECK;
            end
          end
          ST_CHECK: begin
            state_d = ST_IDLE;
            if (sum_q != byte_i) begin
              evt_o.flush = 1'b1;
            end else begin
              evt_o.good = 1'b1;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/lin_frame_receiver.sv]
// LIN slave frame receiver with enhanced checksum and receive ring buffer.
// Pipeline: two register stages (parser/buffer stage, then output register);
// each accepted item passes through both in that order. Throughput: one item
// per cycle while the output is not stalled, set by the single buffer write port and one registered read per item.
// Reset: async active low; parser idle, pointers and frame-seen cleared,
// data_length = 2. Buffer contents are not cleared; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lin_frame_receiver
  import lfr_pkg::*;
#(
  parameter int unsigned BufferDepth = DefaultBufferDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // config: data_length[3:0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [3:0]  cfg_data_i,
  // tdata: rx_byte[7:0]
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,
  // tuser: command[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  // tdata: read_data[7:0], available_count[13:8], frame_good[14],
  //        checksum_failed[15], header_rejected[16], overflow[17], zero[23:18]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [23:0]      m_axis_tdata_o
);

  localparam int unsigned PtrW = $clog2(BufferDepth);
  localparam int unsigned PtrW1 = PtrW + 1;
  localparam int unsigned CntW = (PtrW > 6) ? PtrW : 6;

  logic [3:0] data_len_q;

  logic accept;
  logic out_ready;
  logic s1_adv;

  lfr_evt_t evt;

  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt, rd_nxt;
  logic            seen_q, seen_d;
  logic            full, push, pop, ovf;
  logic [PtrW1-1:0] diff;
  logic [CntW-1:0]  cnt_ext;
  logic [5:0]       avail;

  logic [7:0] mem [BufferDepth];
  logic [7:0] mem_rd_q;

  logic     s1_valid_q;
  lfr_res_t s1_q;
  logic     m_valid_q;
  logic [23:0] m_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_len_q <= 4'd2;
    end else if (cfg_valid_i) begin
      data_len_q <= cfg_data_i;
    end
  end

  assign out_ready       = !m_valid_q || m_axis_tready_i;
  assign s1_adv          = s1_valid_q && out_ready;
  assign s_axis_tready_o = !s1_valid_q || out_ready;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  lfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .cmd_i      (s_axis_tuser_i),
    .byte_i     (s_axis_tdata_i),
    .data_len_i (data_len_q),
    .evt_o      (evt)
  );

  assign wr_nxt = (wr_q == PtrW'(BufferDepth - 1)) ? '0 : wr_q + 1'b1;
  assign rd_nxt = (rd_q == PtrW'(BufferDepth - 1)) ? '0 : rd_q + 1'b1;
  assign full   = (wr_nxt == rd_q);
  assign push   = evt.push && !full;
  assign ovf    = evt.push && full;
  assign pop    = accept && (s_axis_tuser_i == CMD_READ) && seen_q && (wr_q != rd_q);

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    seen_d = seen_q | evt.good;
    if (evt.flush) begin
      wr_d = '0;
      rd_d = '0;
    end else begin
      if (push) wr_d = wr_nxt;
      if (pop)  rd_d = rd_nxt;
    end
  end

  // occupancy after this item, wrapping for any depth
  assign diff = PtrW1'(wr_d) + ((wr_d < rd_d) ? PtrW1'(BufferDepth) : '0) - PtrW1'(rd_d);
  assign cnt_ext = CntW'(diff[PtrW-1:0]);
  assign avail = !seen_d ? '0 :
                 (cnt_ext > CntW'(AvailMax)) ? AvailMax : cnt_ext[5:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      seen_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      seen_q <= seen_d;
    end
  end

  // pop never coincides with a write to the same slot: wr != rd when popping
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= s_axis_tdata_i;
    end
    if (accept) begin
      mem_rd_q <= mem[rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.pop    <= pop;
      s1_q.avail  <= avail;
      s1_q.good   <= evt.good;
      s1_q.failed <= evt.flush;
      s1_q.rej    <= evt.rej;
      s1_q.ovf    <= ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s1_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      m_data_q <= {6'd0, s1_q.ovf, s1_q.rej, s1_q.failed, s1_q.good, s1_q.avail,
                   (s1_q.pop ? mem_rd_q : 8'd0)};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // checksum mismatch clears both pointers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt.flush |=> (wr_q == '0) && (rd_q == '0))
    else $error("pointers not cleared after flush");

  // pointers stay inside the buffer for non power-of-two depths
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_q <= PtrW'(BufferDepth - 1)) && (rd_q <= PtrW'(BufferDepth - 1)))
    else $error("buffer pointer out of range");

  // at most one status flag per result item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ($countones(m_axis_tdata_o[17:14]) <= 1))
    else $error("conflicting status flags");

endmodule

`default_nettype wire
